### rtl/tpq_pkg.sv
// ----------------------------------------------------------------------------
// tpq_pkg
// shared types and constants of the thruster pulse quantizer
// ----------------------------------------------------------------------------
package tpq_pkg;

   // thruster and register map
   localparam int MAX_THR     = 4;
   localparam int THR_W       = 2;
   localparam int CSR_IDX_W   = 4;
   localparam logic [1:0] CSR_BANK_RES = 2'd0;
   localparam logic [1:0] CSR_BANK_MIN = 2'd1;
   localparam logic [31:0] RES_RESET = 32'd1000;
   localparam logic [31:0] MIN_RESET = 32'd0;

   // item fields
   localparam int STAMP_W = 64;
   localparam int TIME_W  = 32;
   localparam int OUT_W   = 33;
   localparam logic OP_CYCLE   = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // saturation factor 101/100
   localparam int SAT_NUM = 101;
   localparam int SAT_DEN = 100;

   // shared divider sizes
   localparam int DIV_W     = 40;
   localparam int DIVS_W    = 33;
   localparam int DIV_STEPS = DIV_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      ADJ_NONE = 2'd0,
      ADJ_MIN  = 2'd1,
      ADJ_ZERO = 2'd2,
      ADJ_SAT  = 2'd3
   } adjust_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PERIOD,
      ST_QUANT,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic              done;
      logic [DIV_W-1:0]  quotient;
      logic [DIVS_W-1:0] remainder;
   } div_out_type;

endpackage

### rtl/tpq_csr.sv
// ----------------------------------------------------------------------------
// tpq_csr
// per-thruster resolution and minimum pulse registers with one read port
// ----------------------------------------------------------------------------
module tpq_csr import tpq_pkg::*; #(
   parameter int NUM_THRUSTERS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [TIME_W-1:0]    wr_data,
   input  logic [THR_W-1:0]     rd_thr,
   output logic [TIME_W-1:0]    rd_res,
   output logic [TIME_W-1:0]    rd_min
);

   logic [TIME_W-1:0] res_ff [MAX_THR];
   logic [TIME_W-1:0] min_ff [MAX_THR];
   logic              wr_res;
   logic              wr_min;
   logic [1:0]        wr_bank;
   logic [THR_W-1:0]  wr_thr;

   // register index decode
   assign wr_bank = wr_index[CSR_IDX_W-1:2];
   assign wr_thr  = wr_index[THR_W-1:0];

   always_comb begin
      wr_res = 1'b0;
      wr_min = 1'b0;
      unique case (wr_bank)
         CSR_BANK_RES: wr_res = wr_en;
         CSR_BANK_MIN: wr_min = wr_en;
         default: ;
      endcase
   end

   // storage, only thrusters that exist take writes
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_THR; i++) begin
         if (reset) begin
            res_ff[i] <= RES_RESET;
            min_ff[i] <= MIN_RESET;
         end else if (i < NUM_THRUSTERS && wr_thr == THR_W'(i)) begin
            if (wr_res) res_ff[i] <= wr_data;
            if (wr_min) min_ff[i] <= wr_data;
         end
      end
   end

   assign rd_res = res_ff[rd_thr];
   assign rd_min = min_ff[rd_thr];

endmodule

### rtl/tpq_div.sv
// ----------------------------------------------------------------------------
// tpq_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tpq_div import tpq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DIVS_W-1:0] divisor,
   output div_out_type       div_out
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]  work_ff, work_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVS_W-1:0] dvs_ff, dvs_in;
   logic [DIVS_W:0]   trial;
   logic              ge;

   // one shift and subtract step
   assign trial = {rem_ff, work_ff[DIV_W-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_STEPS - 1);
         work_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[DIV_W-2:0], ge};
         rem_in  = ge ? DIVS_W'(trial - {1'b0, dvs_ff}) : trial[DIVS_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign div_out.done      = done_ff;
   assign div_out.quotient  = work_ff;
   assign div_out.remainder = rem_ff;

   // partial remainder stays below the divisor
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < dvs_ff)
      else $error("partial remainder not below divisor");

   // no restart while a division runs
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start)
      else $error("divider started while busy");

   // done follows the last step
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff)
      else $error("done without a finished division");

endmodule

### rtl/thruster_pulse_quantizer.sv
// ----------------------------------------------------------------------------
// thruster_pulse_quantizer
// rounds requested thruster on-times to each thruster's resolution, applies
// the minimum pulse and saturates at 1.01 times the control period
// ----------------------------------------------------------------------------
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  op, stamp, thruster, request
//   rsp      out        rsp_valid/rsp_stall  thruster, on-time, adjust
//   csr      in         csr_valid/csr_ready  register index, data
//
// a request and a cycle start with a previous stamp both wait for the 40
// steps of the one shared restoring divider; a request at zero resolution
// skips the divider; other items make no result and leave the block idle.
// the divider works the rounding of requests and the 101/100 saturation
// value, computed at each cycle start with a previous stamp and kept.
// reset is synchronous; all registers are usable in the cycle after it.
// a result waits in the output register under rsp_stall while the next
// item is already taken; the result after it holds the block until the
// register is free; csr_ready is always high.
// ----------------------------------------------------------------------------
module thruster_pulse_quantizer import tpq_pkg::*; #(
   parameter int NUM_THRUSTERS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_op,
   input  logic [STAMP_W-1:0]   req_stamp_ns,
   input  logic [THR_W-1:0]     req_thruster,
   input  logic [TIME_W-1:0]    req_request_ns,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [THR_W-1:0]     rsp_thruster_out,
   output logic [OUT_W-1:0]     rsp_on_time_ns,
   output logic [1:0]           rsp_adjust,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIME_W-1:0]    csr_data
);

   state_type           state_ff, state_in;
   logic                have_prev_ff, have_prev_in;
   logic                have_per_ff, have_per_in;
   logic [STAMP_W-1:0]  prev_ff, prev_in;
   logic [TIME_W-1:0]   per_ff, per_in;
   logic [OUT_W-1:0]    sat_ff, sat_in;
   logic [THR_W-1:0]    thr_ff, thr_in;
   logic [TIME_W+1:0]   num_ff, num_in;
   logic [OUT_W-1:0]    q_ff, q_in;
   logic                out_vld_ff, out_vld_in;
   logic [THR_W-1:0]    out_thr_ff, out_thr_in;
   logic [OUT_W-1:0]    out_time_ff, out_time_in;
   adjust_type          out_adj_ff, out_adj_in;

   logic                accept;
   logic [THR_W-1:0]    rd_thr;
   logic [TIME_W-1:0]   rd_res;
   logic [TIME_W-1:0]   rd_min;
   logic                div_start;
   logic [DIV_W-1:0]    div_dividend;
   logic [DIVS_W-1:0]   div_divisor;
   div_out_type         div_out;
   logic [STAMP_W-1:0]  diff;
   logic [TIME_W-1:0]   per_sat;
   logic [TIME_W+1:0]   num_new;
   logic [TIME_W+1:0]   q_even;
   logic                out_free;
   logic                thr_ok;

   // configuration registers
   assign csr_ready = 1'b1;
   assign rd_thr    = (state_ff == ST_IDLE) ? req_thruster : thr_ff;

   tpq_csr #(
      .NUM_THRUSTERS (NUM_THRUSTERS)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .rd_thr   (rd_thr),
      .rd_res   (rd_res),
      .rd_min   (rd_min)
   );

   // shared divider
   tpq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .div_out  (div_out)
   );

   // datapath helpers
   assign accept   = req_valid & ~req_stall;
   assign diff     = req_stamp_ns - prev_ff;
   assign per_sat  = (|diff[STAMP_W-1:TIME_W]) ? '1 : diff[TIME_W-1:0];
   assign num_new  = {1'b0, req_request_ns, 1'b0} + {2'b00, rd_res};
   assign q_even   = num_ff - {1'b0, div_out.remainder};
   assign out_free = ~out_vld_ff | ~rsp_stall;
   assign thr_ok   = 32'(req_thruster) < NUM_THRUSTERS;
   assign req_stall = (state_ff != ST_IDLE);

   // sequencer and next values
   always_comb begin
      state_in     = state_ff;
      have_prev_in = have_prev_ff;
      have_per_in  = have_per_ff;
      prev_in      = prev_ff;
      per_in       = per_ff;
      sat_in       = sat_ff;
      thr_in       = thr_ff;
      num_in       = num_ff;
      q_in         = q_ff;
      out_vld_in   = out_vld_ff & rsp_stall;
      out_thr_in   = out_thr_ff;
      out_time_in  = out_time_ff;
      out_adj_in   = out_adj_ff;
      div_start    = 1'b0;
      div_dividend = DIV_W'({8'd0, per_sat} * DIV_W'(SAT_NUM));
      div_divisor  = DIVS_W'(SAT_DEN);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_CYCLE) begin
                  prev_in      = req_stamp_ns;
                  have_prev_in = 1'b1;
                  if (have_prev_ff) begin
                     per_in      = per_sat;
                     have_per_in = 1'b1;
                     div_start   = 1'b1;
                     state_in    = ST_PERIOD;
                  end
               end else if (have_per_ff && thr_ok) begin
                  thr_in = req_thruster;
                  num_in = num_new;
                  if (rd_res == '0) begin
                     q_in     = {1'b0, req_request_ns};
                     state_in = ST_DECIDE;
                  end else begin
                     div_start    = 1'b1;
                     div_dividend = DIV_W'(num_new);
                     div_divisor  = {rd_res, 1'b0};
                     state_in     = ST_QUANT;
                  end
               end
            end
         end
         ST_PERIOD: begin
            if (div_out.done) begin
               sat_in   = div_out.quotient[OUT_W-1:0];
               state_in = ST_IDLE;
            end
         end
         ST_QUANT: begin
            if (div_out.done) begin
               q_in     = q_even[OUT_W:1];
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               out_vld_in = 1'b1;
               out_thr_in = thr_ff;
               if (q_ff < {1'b0, rd_min}) begin
                  if ({q_ff, 1'b0} >= {2'b00, rd_min}) begin
                     out_time_in = {1'b0, rd_min};
                     out_adj_in  = ADJ_MIN;
                  end else begin
                     out_time_in = '0;
                     out_adj_in  = ADJ_ZERO;
                  end
               end else if (q_ff >= {1'b0, per_ff}) begin
                  out_time_in = sat_ff;
                  out_adj_in  = ADJ_SAT;
               end else begin
                  out_time_in = q_ff;
                  out_adj_in  = ADJ_NONE;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         have_per_ff  <= 1'b0;
         prev_ff      <= '0;
         per_ff       <= '0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         have_per_ff  <= have_per_in;
         prev_ff      <= prev_in;
         per_ff       <= per_in;
         out_vld_ff   <= out_vld_in;
      end
      sat_ff      <= sat_in;
      thr_ff      <= thr_in;
      num_ff      <= num_in;
      q_ff        <= q_in;
      out_thr_ff  <= out_thr_in;
      out_time_ff <= out_time_in;
      out_adj_ff  <= out_adj_in;
   end

   // result word
   assign rsp_valid        = out_vld_ff;
   assign rsp_thruster_out = out_thr_ff;
   assign rsp_on_time_ns   = out_time_ff;
   assign rsp_adjust       = out_adj_ff;

   // a dropped pulse reads zero
   a_zero_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_adjust == ADJ_ZERO |-> rsp_on_time_ns == '0)
      else $error("dropped pulse with nonzero on-time");

   // divider finishes only while the sequencer waits for it
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_out.done |-> (state_ff == ST_PERIOD || state_ff == ST_QUANT))
      else $error("divider done outside a divide state");

   // results only name thrusters that exist
   a_thr_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_thruster_out) < NUM_THRUSTERS)
      else $error("result for a missing thruster");

   // a new result is loaded only into a free output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DECIDE && rsp_valid && rsp_stall |=> state_ff == ST_DECIDE)
      else $error("result dropped under stall");

endmodule

### dv/thruster_pulse_quantizer_tb.sv
// ----------------------------------------------------------------------------
// thruster_pulse_quantizer_tb
// self-checking bench: directed corner cases, then random cycle starts and
// on-time requests under random stalls; each result word is checked against
// an in-bench predictor of the quantizer
// ----------------------------------------------------------------------------
module thruster_pulse_quantizer_tb import tpq_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_THR       = 4;
   localparam int SETTLE_CYCLES = 60;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RAND_PHASES   = 20;
   localparam int PHASE_ITEMS   = 100;
   localparam int QUIET_PHASES  = 3;
   localparam int HOLD_CYCLES   = 400;

   // register banks that decode to nothing
   localparam logic [1:0] BANK_SPARE_A = 2'd2;
   localparam logic [1:0] BANK_SPARE_B = 2'd3;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   typedef struct {
      logic [THR_W-1:0] thr;
      logic [OUT_W-1:0] on_time;
      adjust_type       adj;
   } pulse_word_type;

   // clock, reset and ports
   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_op;
   logic [STAMP_W-1:0]   req_stamp_ns;
   logic [THR_W-1:0]     req_thruster;
   logic [TIME_W-1:0]    req_request_ns;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [THR_W-1:0]     rsp_thruster_out;
   logic [OUT_W-1:0]     rsp_on_time_ns;
   logic [1:0]           rsp_adjust;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TIME_W-1:0]    csr_data;

   // predictor state and register copy
   logic [STAMP_W-1:0] last_stamp;
   bit                 stamp_seen;
   logic [TIME_W-1:0]  ctrl_period;
   bit                 period_known;
   logic [TIME_W-1:0]  res_cfg [NUM_THR];
   logic [TIME_W-1:0]  min_cfg [NUM_THR];
   pulse_word_type     expected_pulses [$];

   // bench control
   bit src_gaps;
   bit snk_gaps;
   int stall_hold_len;
   int hold_left;
   int burst_left;
   int mismatch_count;
   int cycle_count;

   thruster_pulse_quantizer #(
      .NUM_THRUSTERS(NUM_THR)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_stamp_ns    (req_stamp_ns),
      .req_thruster    (req_thruster),
      .req_request_ns  (req_request_ns),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_thruster_out(rsp_thruster_out),
      .rsp_on_time_ns  (rsp_on_time_ns),
      .rsp_adjust      (rsp_adjust),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words pending", cycle_count,
                  expected_pulses.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      mismatch_count++;
      $display("ERROR %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // expected word for one accepted item, if it makes one
   function automatic void predict_pulse(input logic op, input logic [STAMP_W-1:0] stamp,
                                         input logic [THR_W-1:0] thr,
                                         input logic [TIME_W-1:0] req);
      logic [63:0] diff;
      logic [63:0] res64;
      logic [63:0] q;
      logic [63:0] mn;
      logic [63:0] per;
      pulse_word_type w;
      if (op == OP_CYCLE) begin
         if (stamp_seen) begin
            diff = stamp - last_stamp;
            ctrl_period = (diff > {32'd0, ALL_ONES}) ? ALL_ONES : diff[31:0];
            period_known = 1'b1;
         end
         last_stamp = stamp;
         stamp_seen = 1'b1;
         return;
      end
      if (!period_known || thr >= NUM_THR)
         return;
      // half-up rounding to a multiple of the resolution
      res64 = {32'd0, res_cfg[thr]};
      if (res64 == 64'd0)
         q = {32'd0, req};
      else
         q = ((({32'd0, req}) << 1) + res64) / (res64 << 1) * res64;
      mn  = {32'd0, min_cfg[thr]};
      per = {32'd0, ctrl_period};
      // minimum pulse first, then period saturation
      if (q < mn) begin
         if ((q << 1) >= mn) begin
            q = mn;
            w.adj = ADJ_MIN;
         end else begin
            q = 64'd0;
            w.adj = ADJ_ZERO;
         end
      end else if (q >= per) begin
         q = per * 64'(SAT_NUM) / 64'(SAT_DEN);
         w.adj = ADJ_SAT;
      end else begin
         w.adj = ADJ_NONE;
      end
      w.thr = thr;
      w.on_time = q[OUT_W-1:0];
      expected_pulses.push_back(w);
   endfunction

   // result checker
   always @(posedge clock) begin
      pulse_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pulses.size() == 0) begin
            report_mismatch("result word with none pending", 64'(rsp_on_time_ns), 64'd0);
         end else begin
            w = expected_pulses.pop_front();
            if (rsp_thruster_out !== w.thr)
               report_mismatch("thruster_out", 64'(rsp_thruster_out), 64'(w.thr));
            if (rsp_on_time_ns !== w.on_time)
               report_mismatch("on_time_ns", 64'(rsp_on_time_ns), 64'(w.on_time));
            if (rsp_adjust !== w.adj)
               report_mismatch("adjust", 64'(rsp_adjust), 64'(w.adj));
         end
      end
   end

   // receiver stalls: long hold-off on request, else short random bursts
   always @(negedge clock) begin
      if (stall_hold_len > 0) begin
         hold_left = stall_hold_len;
         stall_hold_len = 0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (burst_left > 0) begin
         rsp_stall <= 1'b1;
         burst_left--;
      end else if (snk_gaps && $urandom_range(0, 3) == 0) begin
         rsp_stall <= 1'b1;
         burst_left = $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // offer one word and wait until it is taken
   task automatic send_word(input logic op, input logic [STAMP_W-1:0] stamp,
                            input logic [THR_W-1:0] thr, input logic [TIME_W-1:0] req);
      @(negedge clock);
      if (src_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_op         <= op;
      req_stamp_ns   <= stamp;
      req_thruster   <= thr;
      req_request_ns <= req;
      req_valid      <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_pulse(op, stamp, thr, req);
   endtask

   // stop sending, let every result drain and the block settle
   task automatic wait_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_pulses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] bank, input logic [THR_W-1:0] thr,
                            input logic [TIME_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= {bank, thr};
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (bank == CSR_BANK_RES)
         res_cfg[thr] = data;
      else if (bank == CSR_BANK_MIN)
         min_cfg[thr] = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // requests before a period exists, first stamp only stored, wrapping stamp
   task automatic test_startup();
      send_word(OP_REQUEST, 64'd0, 2'd0, 32'd1000);
      send_word(OP_CYCLE, 64'hFFFF_FFFF_FFFF_FF00, 2'd0, 32'd0);
      send_word(OP_REQUEST, 64'd0, 2'd1, 32'd1000);
      send_word(OP_CYCLE, 64'h0000_0000_0000_4E1F, 2'd0, 32'd0);
   endtask

   // default resolution: half-up rounding and saturation at the period
   task automatic test_rounding();
      send_word(OP_REQUEST, 64'd0, 2'd0, 32'd0);
      send_word(OP_REQUEST, 64'd0, 2'd1, 32'd499);
      send_word(OP_REQUEST, 64'd0, 2'd2, 32'd500);
      send_word(OP_REQUEST, 64'd0, 2'd3, 32'd1499);
      send_word(OP_REQUEST, 64'd0, 2'd0, 32'd20254);
      send_word(OP_REQUEST, 64'd0, 2'd1, 32'd20500);
      send_word(OP_REQUEST, 64'd0, 2'd2, ALL_ONES);
   endtask

   // minimum pulse raise and drop, zero and full-scale resolution
   task automatic test_min_pulse();
      wait_quiet();
      write_reg(CSR_BANK_MIN, 2'd0, 32'd5000);
      write_reg(CSR_BANK_RES, 2'd1, ALL_ONES);
      write_reg(CSR_BANK_MIN, 2'd1, ALL_ONES);
      write_reg(CSR_BANK_RES, 2'd2, 32'd1);
      write_reg(CSR_BANK_MIN, 2'd2, 32'd3000);
      write_reg(CSR_BANK_RES, 2'd3, 32'd0);
      write_reg(CSR_BANK_MIN, 2'd3, 32'd7);
      send_word(OP_REQUEST, 64'd0, 2'd0, 32'd2400);
      send_word(OP_REQUEST, 64'd0, 2'd0, 32'd2600);
      send_word(OP_REQUEST, 64'd0, 2'd0, 32'd5000);
      send_word(OP_REQUEST, 64'd0, 2'd1, 32'h7FFF_FFFF);
      send_word(OP_REQUEST, 64'd0, 2'd1, 32'h8000_0000);
      send_word(OP_REQUEST, 64'd0, 2'd2, 32'd2999);
      send_word(OP_REQUEST, 64'd0, 2'd3, 32'd6);
      send_word(OP_REQUEST, 64'd0, 2'd3, 32'd20255);
   endtask

   // zero period, saturated period, full-width stamps
   task automatic test_period_cases();
      send_word(OP_CYCLE, last_stamp, 2'd0, 32'd0);
      send_word(OP_REQUEST, 64'd0, 2'd0, 32'd5000);
      send_word(OP_REQUEST, 64'd0, 2'd2, 32'd0);
      send_word(OP_CYCLE, last_stamp + 64'h0000_0100_0000_0000, 2'd0, 32'd0);
      send_word(OP_REQUEST, 64'd0, 2'd0, ALL_ONES);
      send_word(OP_CYCLE, 64'hFEDC_BA98_7654_3210, 2'd0, 32'd0);
      send_word(OP_CYCLE, 64'hFEDC_BA98_7654_3210 + 64'd20000, 2'd0, 32'd0);
      send_word(OP_REQUEST, 64'd0, 2'd2, 32'd19999);
   endtask

   // writes to indexes above the register map change nothing
   task automatic test_spare_index();
      wait_quiet();
      for (int t = 0; t < NUM_THR; t++) begin
         write_reg(BANK_SPARE_A, t[THR_W-1:0], 32'hA5A5_5A5A);
         write_reg(BANK_SPARE_B, t[THR_W-1:0], 32'h5A5A_A5A5);
      end
      send_word(OP_REQUEST, 64'd0, 2'd0, 32'd12345);
   endtask

   // receiver holds off while requests keep coming, block must back up
   task automatic test_backpressure();
      wait_quiet();
      stall_hold_len = HOLD_CYCLES;
      for (int i = 0; i < 12; i++)
         send_word(OP_REQUEST, 64'd0, 2'($urandom_range(0, 3)), $urandom_range(0, 30000));
   endtask

   // random phases: fresh settings, then cycle starts and requests
   task automatic test_random();
      logic [TIME_W-1:0]  val;
      logic [TIME_W-1:0]  req;
      logic [STAMP_W-1:0] stamp;
      logic [THR_W-1:0]   thr;
      int                 off;
      for (int p = 0; p < RAND_PHASES; p++) begin
         wait_quiet();
         // new register settings, extremes included
         for (int t = 0; t < NUM_THR; t++) begin
            case ($urandom_range(0, 9))
               0:       val = 32'd1;
               1:       val = 32'd0;
               2:       val = ALL_ONES;
               3:       val = $urandom;
               4, 5:    val = $urandom_range(1, 100000);
               default: val = $urandom_range(1, 2000);
            endcase
            write_reg(CSR_BANK_RES, t[THR_W-1:0], val);
            case ($urandom_range(0, 9))
               0:       val = ALL_ONES;
               1:       val = $urandom;
               2, 3:    val = $urandom_range(0, 100000);
               4, 5:    val = res_cfg[t] * $urandom_range(1, 5);
               default: val = 32'd0;
            endcase
            write_reg(CSR_BANK_MIN, t[THR_W-1:0], val);
         end
         if (p >= RAND_PHASES - QUIET_PHASES) begin
            src_gaps = 1'b0;
            snk_gaps = 1'b0;
         end else begin
            src_gaps = ($urandom_range(0, 3) != 0);
            snk_gaps = ($urandom_range(0, 3) != 0);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (!period_known || $urandom_range(0, 5) == 0) begin
               // cycle start, mostly ordinary periods
               case ($urandom_range(0, 9))
                  0:       stamp = last_stamp;
                  1:       stamp = last_stamp + {32'd0, $urandom};
                  2:       stamp = last_stamp + {30'd0, 2'($urandom_range(1, 3)), $urandom};
                  3:       stamp = {$urandom, $urandom};
                  default: stamp = last_stamp + 64'($urandom_range(1, 200000));
               endcase
               send_word(OP_CYCLE, stamp, 2'($urandom), $urandom);
            end else begin
               // request near the interesting thresholds
               thr = 2'($urandom_range(0, 3));
               off = int'($urandom_range(0, 64)) - 32;
               case ($urandom_range(0, 7))
                  0: req = $urandom;
                  1: req = ctrl_period + 32'(off);
                  2: req = min_cfg[thr] + 32'(off);
                  3: req = (min_cfg[thr] >> 1) + 32'(off);
                  4: req = res_cfg[thr] * $urandom_range(0, 50) + (res_cfg[thr] >> 1)
                           + 32'(off % 2);
                  5: req = $urandom_range(0, 3000);
                  6: req = (ctrl_period == 32'd0) ? 32'd0 : $urandom_range(0, ctrl_period);
                  default: req = ($urandom_range(0, 1) == 0) ? 32'd0 : ALL_ONES;
               endcase
               send_word(OP_REQUEST, {$urandom, $urandom}, thr, req);
            end
         end
      end
   endtask

   // stimulus sequence
   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_CYCLE;
      req_stamp_ns   = '0;
      req_thruster   = '0;
      req_request_ns = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      src_gaps       = 1'b1;
      snk_gaps       = 1'b1;
      stall_hold_len = 0;
      hold_left      = 0;
      burst_left     = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      last_stamp     = '0;
      stamp_seen     = 1'b0;
      ctrl_period    = '0;
      period_known   = 1'b0;
      for (int t = 0; t < NUM_THR; t++) begin
         res_cfg[t] = RES_RESET;
         min_cfg[t] = MIN_RESET;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_startup();
      test_rounding();
      test_min_pulse();
      test_period_cases();
      test_spare_index();
      test_backpressure();
      test_random();
      wait_quiet();

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
